### hdl/irpdt_pkg.sv
// Package for the pulse-distance infrared transmitter.
// Holds command codes, register indexes, phase type and default sizes.
// No dependencies.
package irpdt_pkg;

    localparam int unsigned CODE_BITS_DEF    = 24;
    localparam int unsigned ADDRESS_BITS_DEF = 8;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned CODE_W = 24;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned TICK_W = 8;

    localparam logic [TICK_W-1:0] LEADER_MARK_RST  = 8'd16;
    localparam logic [TICK_W-1:0] LEADER_SPACE_RST = 8'd8;

    localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CARRIER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE = 2'd1;

    localparam logic [1:0] SPACE_ZERO = 2'd1;
    localparam logic [1:0] SPACE_ONE  = 2'd3;

    typedef enum logic [5:0] {
        PH_LEADER_MARK  = 6'b000001,
        PH_LEADER_SPACE = 6'b000010,
        PH_ADDRESS      = 6'b000100,
        PH_CODE         = 6'b001000,
        PH_STOP         = 6'b010000,
        PH_IDLE         = 6'b100000
    } t_phase;

endpackage

### hdl/ir_pulse_distance_transmitter_core.sv
// Pulse-distance infrared frame transmitter: event-driven frame sequencer,
// carrier gating and a registered result stage. Depends on irpdt_pkg.
// The result is registered and goes valid in the cycle after the request is accepted.
// Throughput: one request per cycle; a held result stalls input while i_ready is low.
// Reset (synchronous, active low) sends the sequencer idle, its pin level low,
// leader lengths to 16 and 8 ticks, and clears result valid; result data is not reset.
module ir_pulse_distance_transmitter_core
    import irpdt_pkg::*;
#(
    parameter int unsigned CODE_BITS    = CODE_BITS_DEF,
    parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [CODE_W-1:0]     i_code,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_ir_pin,
    output logic                  o_busy_res,
    output logic                  o_mark_active,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned BL_W = $clog2(CODE_BITS + 1);

    logic [TICK_W-1:0]    r_leader_mark, r_leader_space;
    t_phase               r_phase, n_phase;
    logic [TICK_W-1:0]    r_tick_counter, n_tick_counter;
    logic [1:0]           r_space_left, n_space_left;
    logic [BL_W-1:0]      r_bits_left, n_bits_left;
    logic [CODE_BITS-1:0] r_code_shift, n_code_shift;
    logic                 r_envelope, n_envelope;
    logic                 r_carrier_level, n_carrier_level;
    logic                 r_blast_enable, n_blast_enable;
    logic                 r_pin_level, n_pin_level;
    logic                 r_out_valid;
    logic                 r_ir_pin, r_busy_res, r_mark_active;
    logic                 w_accept;
    logic [31:0]          w_code_ext;
    logic [TICK_W-1:0]    w_tick_inc;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_code_ext = {{(32 - CODE_W){1'b0}}, i_code};
    assign w_tick_inc = r_tick_counter + 8'd1;

    always_comb begin
        n_phase         = r_phase;
        n_tick_counter  = r_tick_counter;
        n_space_left    = r_space_left;
        n_bits_left     = r_bits_left;
        n_code_shift    = r_code_shift;
        n_envelope      = r_envelope;
        n_carrier_level = r_carrier_level;
        n_blast_enable  = r_blast_enable;
        n_pin_level     = r_pin_level;
        if (i_command == CMD_START) begin
            n_code_shift   = w_code_ext[CODE_BITS-1:0];
            n_bits_left    = BL_W'(CODE_BITS);
            n_phase        = PH_LEADER_MARK;
            n_tick_counter = '0;
            n_space_left   = '0;
            n_envelope     = 1'b0;
            n_blast_enable = 1'b1;
        end else if (i_command == CMD_TICK) begin
            unique case (r_phase)
                PH_LEADER_MARK: begin
                    n_envelope     = 1'b1;
                    n_tick_counter = w_tick_inc;
                    if (w_tick_inc == r_leader_mark) begin
                        n_tick_counter = '0;
                        n_phase        = PH_LEADER_SPACE;
                    end
                end
                PH_LEADER_SPACE: begin
                    n_envelope     = 1'b0;
                    n_tick_counter = w_tick_inc;
                    if (w_tick_inc == r_leader_space) begin
                        n_tick_counter = '0;
                        n_phase        = PH_ADDRESS;
                    end
                end
                PH_ADDRESS: begin
                    if (r_space_left != 2'd0) begin
                        n_envelope     = 1'b0;
                        n_space_left   = '0;
                        n_tick_counter = w_tick_inc;
                    end else begin
                        n_envelope   = 1'b1;
                        n_space_left = 2'd1;
                    end
                    if (n_tick_counter >= TICK_W'(ADDRESS_BITS)) begin
                        n_tick_counter = '0;
                        n_space_left   = '0;
                        n_envelope     = 1'b0;
                        n_phase        = PH_CODE;
                    end
                end
                PH_CODE: begin
                    if (r_space_left == 2'd0) begin
                        if (r_bits_left == '0) begin
                            n_tick_counter = '0;
                            n_phase        = PH_STOP;
                        end else begin
                            n_code_shift = r_code_shift << 1;
                            n_space_left = r_code_shift[CODE_BITS-1] ? SPACE_ONE : SPACE_ZERO;
                            n_envelope   = 1'b1;
                            n_bits_left  = r_bits_left - BL_W'(1);
                        end
                    end else begin
                        n_space_left = r_space_left - 2'd1;
                        n_envelope   = 1'b0;
                    end
                end
                PH_STOP: begin
                    if (r_tick_counter == '0) begin
                        n_envelope     = 1'b1;
                        n_tick_counter = 8'd1;
                    end else begin
                        n_envelope     = 1'b0;
                        n_phase        = PH_IDLE;
                        n_blast_enable = 1'b0;
                    end
                end
                PH_IDLE: begin
                end
                default: begin
                end
            endcase
        end else if (i_command == CMD_CARRIER) begin
            if (r_blast_enable) begin
                if (r_envelope) begin
                    n_carrier_level = !r_carrier_level;
                    n_pin_level     = !r_carrier_level;
                end else begin
                    n_pin_level = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader_mark  <= LEADER_MARK_RST;
            r_leader_space <= LEADER_SPACE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_LEADER_MARK) begin
                r_leader_mark <= i_cfg_data;
            end else if (i_cfg_index == REG_LEADER_SPACE) begin
                r_leader_space <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_tick_counter  <= '0;
            r_space_left    <= '0;
            r_bits_left     <= BL_W'(CODE_BITS);
            r_code_shift    <= '0;
            r_envelope      <= 1'b0;
            r_carrier_level <= 1'b0;
            r_blast_enable  <= 1'b0;
            r_pin_level     <= 1'b0;
        end else if (w_accept) begin
            r_phase         <= n_phase;
            r_tick_counter  <= n_tick_counter;
            r_space_left    <= n_space_left;
            r_bits_left     <= n_bits_left;
            r_code_shift    <= n_code_shift;
            r_envelope      <= n_envelope;
            r_carrier_level <= n_carrier_level;
            r_blast_enable  <= n_blast_enable;
            r_pin_level     <= n_pin_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ir_pin      <= n_pin_level;
            r_busy_res    <= n_blast_enable;
            r_mark_active <= n_envelope;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_ir_pin      = r_ir_pin;
    assign o_busy_res    = r_busy_res;
    assign o_mark_active = r_mark_active;

`ifndef NO_ASSERTIONS
    a_env_needs_blast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_envelope |-> r_blast_enable)
        else $error("envelope on while carrier disarmed");

    a_idle_iff_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) == !r_blast_enable)
        else $error("idle phase and carrier arm disagree");

    a_space_in_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_space_left != 2'd0) |-> (r_phase == PH_ADDRESS || r_phase == PH_CODE))
        else $error("space count outside bit phases");

    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_left <= BL_W'(CODE_BITS))
        else $error("bit count above code width");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (o_busy_res == r_blast_enable && o_mark_active == r_envelope))
        else $error("result register disagrees with sequencer state");
`endif

endmodule

### bench/tb_ir_pulse_distance_transmitter_core.sv
// Testbench for ir_pulse_distance_transmitter_core: directed rows, leader tests, random frames.
// Results are checked against typed rows or a cycle-free predictor of sequencer and carrier.
// Depends on irpdt_pkg and the core RTL.
module tb_ir_pulse_distance_transmitter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import irpdt_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 2'd3;
    localparam int DIR_ROWS      = 18;
    localparam int ITEM_BUDGET   = 850;
    localparam int QUIET_FROM    = 400;
    localparam int QUIET_TO      = 600;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic pin;
        logic busy;
        logic mark;
    } t_tx_out;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CODE_W-1:0] code;
        logic              typed;
        t_tx_out           out;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [CMD_W-1:0]      i_command = CMD_TICK;
    logic [CODE_W-1:0]     i_code = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_ir_pin;
    logic                  o_busy_res;
    logic                  o_mark_active;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ir_pulse_distance_transmitter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_code        (i_code),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_ir_pin      (o_ir_pin),
        .o_busy_res    (o_busy_res),
        .o_mark_active (o_mark_active),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predicted transmitter state
    t_phase       seq_phase;
    logic [7:0]   seq_count;
    logic [1:0]   seq_space;
    logic [4:0]   seq_bits_left;
    logic [23:0]  seq_code;
    logic         seq_env;
    logic         seq_carrier;
    logic         seq_armed;
    logic         seq_pin;
    logic [7:0]   mark_len;
    logic [7:0]   space_len;

    t_tx_out frame_out_q[$];
    int      n_items = 0;
    int      mismatches = 0;
    bit      idle_on = 1'b1;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{CMD_TICK,    24'h000000, 1'b1, 3'b000},
        '{CMD_CARRIER, 24'h000000, 1'b1, 3'b000},
        '{CMD_UNUSED,  24'hFFFFFF, 1'b1, 3'b000},
        '{CMD_START,   24'hFFFFFF, 1'b1, 3'b010},
        '{CMD_CARRIER, 24'h000000, 1'b1, 3'b010},
        '{CMD_TICK,    24'h000000, 1'b1, 3'b011},
        '{CMD_CARRIER, 24'h000000, 1'b1, 3'b111},
        '{CMD_CARRIER, 24'hFFFFFF, 1'b1, 3'b011},
        '{CMD_CARRIER, 24'h000000, 1'b1, 3'b111},
        '{CMD_START,   24'h000000, 1'b1, 3'b110},
        '{CMD_CARRIER, 24'h000000, 1'b1, 3'b010},
        '{CMD_TICK,    24'hFFFFFF, 1'b1, 3'b011},
        '{CMD_CARRIER, 24'h000000, 1'b1, 3'b011},
        '{CMD_UNUSED,  24'h000000, 1'b1, 3'b011},
        '{CMD_START,   24'h800001, 1'b0, 3'b000},
        '{CMD_TICK,    24'h000000, 1'b0, 3'b000},
        '{CMD_CARRIER, 24'h000000, 1'b0, 3'b000},
        '{CMD_TICK,    24'h000000, 1'b0, 3'b000}
    };

    function automatic void reset_transmitter();
        seq_phase     = PH_IDLE;
        seq_count     = '0;
        seq_space     = '0;
        seq_bits_left = 5'(CODE_BITS_DEF);
        seq_code      = '0;
        seq_env       = 1'b0;
        seq_carrier   = 1'b0;
        seq_armed     = 1'b0;
        seq_pin       = 1'b0;
        mark_len      = LEADER_MARK_RST;
        space_len     = LEADER_SPACE_RST;
    endfunction

    function automatic t_tx_out step_transmitter(logic [CMD_W-1:0] cmd, logic [CODE_W-1:0] code);
        t_tx_out res;
        case (cmd)
            CMD_START: begin
                seq_code      = code;
                seq_bits_left = 5'(CODE_BITS_DEF);
                seq_phase     = PH_LEADER_MARK;
                seq_count     = '0;
                seq_space     = '0;
                seq_env       = 1'b0;
                seq_armed     = 1'b1;
            end
            CMD_TICK: begin
                case (seq_phase)
                    PH_LEADER_MARK: begin
                        seq_env   = 1'b1;
                        seq_count = seq_count + 8'd1;
                        if (seq_count == mark_len) begin
                            seq_count = '0;
                            seq_phase = PH_LEADER_SPACE;
                        end
                    end
                    PH_LEADER_SPACE: begin
                        seq_env   = 1'b0;
                        seq_count = seq_count + 8'd1;
                        if (seq_count == space_len) begin
                            seq_count = '0;
                            seq_phase = PH_ADDRESS;
                        end
                    end
                    PH_ADDRESS: begin
                        if (seq_space != 0) begin
                            seq_env   = 1'b0;
                            seq_space = '0;
                            seq_count = seq_count + 8'd1;
                        end else begin
                            seq_env   = 1'b1;
                            seq_space = 2'd1;
                        end
                        if (seq_count >= ADDRESS_BITS_DEF) begin
                            seq_count = '0;
                            seq_space = '0;
                            seq_env   = 1'b0;
                            seq_phase = PH_CODE;
                        end
                    end
                    PH_CODE: begin
                        if (seq_space == 0) begin
                            if (seq_bits_left == 0) begin
                                seq_count = '0;
                                seq_phase = PH_STOP;
                            end else begin
                                seq_space     = seq_code[23] ? SPACE_ONE : SPACE_ZERO;
                                seq_code      = {seq_code[22:0], 1'b0};
                                seq_env       = 1'b1;
                                seq_bits_left = seq_bits_left - 5'd1;
                            end
                        end else begin
                            seq_space = seq_space - 2'd1;
                            seq_env   = 1'b0;
                        end
                    end
                    PH_STOP: begin
                        if (seq_count == 0) begin
                            seq_env   = 1'b1;
                            seq_count = 8'd1;
                        end else begin
                            seq_env   = 1'b0;
                            seq_phase = PH_IDLE;
                            seq_armed = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_CARRIER: begin
                if (seq_armed) begin
                    if (seq_env) begin
                        seq_carrier = ~seq_carrier;
                        seq_pin     = seq_carrier;
                    end else begin
                        seq_pin = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        res.pin  = seq_pin;
        res.busy = seq_armed;
        res.mark = seq_env;
        return res;
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '1;
        if (r == 1)
            return '0;
        return CODE_W'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_len();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 8'd1;
        if (r == 1)
            return 8'd16;
        return CFG_DATA_W'($urandom_range(1, 12));
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        mismatches++;
    endtask

    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                              input bit typed, input t_tx_out typed_out);
        t_tx_out want;
        idle_on = !(n_items >= QUIET_FROM && n_items < QUIET_TO);
        while (idle_on && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_code    <= code;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        want = step_transmitter(cmd, code);
        frame_out_q.push_back(typed ? typed_out : want);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic settle_idle();
        i_valid <= 1'b0;
        while (frame_out_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        case (idx)
            REG_LEADER_MARK:  mark_len = data;
            REG_LEADER_SPACE: space_len = data;
            default: ;
        endcase
    endtask

    task automatic run_frame(input int carrier_pct);
        int r;
        bit restarted;
        restarted = 1'b0;
        send_event(CMD_START, pick_code(), 1'b0, '0);
        while (seq_phase != PH_IDLE) begin
            r = $urandom_range(99);
            if (r < carrier_pct)
                send_event(CMD_CARRIER, pick_code(), 1'b0, '0);
            else if (r < carrier_pct + 2)
                send_event(CMD_UNUSED, pick_code(), 1'b0, '0);
            else if (r == 99 && !restarted) begin
                restarted = 1'b1;
                send_event(CMD_START, pick_code(), 1'b0, '0);
            end else
                send_event(CMD_TICK, pick_code(), 1'b0, '0);
        end
        // events while idle
        repeat ($urandom_range(3)) begin
            r = $urandom_range(2);
            send_event(r == 0 ? CMD_TICK : (r == 1 ? CMD_CARRIER : CMD_UNUSED),
                       pick_code(), 1'b0, '0);
        end
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_ready <= !idle_on || ($urandom_range(99) >= 10);
    end

    always @(posedge i_clk) begin
        t_tx_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (frame_out_q.size() == 0) begin
                report_mismatch("result with no request pending", 0, 1);
            end else begin
                want = frame_out_q.pop_front();
                if (o_ir_pin !== want.pin)
                    report_mismatch("ir_pin", want.pin, o_ir_pin);
                if (o_busy_res !== want.busy)
                    report_mismatch("busy_res", want.busy, o_busy_res);
                if (o_mark_active !== want.mark)
                    report_mismatch("mark_active", want.mark, o_mark_active);
            end
        end
    end

    initial begin
        int r;
        reset_transmitter();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_reg(REG_UNMAPPED_A, 8'hFF);
        write_reg(REG_UNMAPPED_B, 8'h00);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        foreach (dir_rows[k])
            send_event(dir_rows[k].cmd, dir_rows[k].code, dir_rows[k].typed, dir_rows[k].out);

        // long leaders: rewrite the mark length below the running count, zero space length
        settle_idle();
        write_reg(REG_LEADER_MARK, 8'd255);
        write_reg(REG_LEADER_SPACE, 8'd0);
        i_cfg_we <= 1'b0;
        send_event(CMD_START, pick_code(), 1'b0, '0);
        repeat (5) send_event(CMD_TICK, pick_code(), 1'b0, '0);
        settle_idle();
        write_reg(REG_LEADER_MARK, 8'd2);
        i_cfg_we <= 1'b0;
        while (seq_phase != PH_IDLE) begin
            r = $urandom_range(99);
            send_event(r < 10 ? CMD_CARRIER : CMD_TICK, pick_code(), 1'b0, '0);
        end

        settle_idle();
        write_reg(REG_LEADER_MARK, LEADER_MARK_RST);
        write_reg(REG_LEADER_SPACE, LEADER_SPACE_RST);
        i_cfg_we <= 1'b0;
        while (n_items < ITEM_BUDGET) begin
            if ($urandom_range(99) < 30) begin
                settle_idle();
                write_reg(REG_LEADER_MARK, pick_len());
                write_reg(REG_LEADER_SPACE, pick_len());
                i_cfg_we <= 1'b0;
            end
            run_frame($urandom_range(20, 50));
        end

        settle_idle();
        if (mismatches == 0)
            $display("[ir_pulse_distance_transmitter_core] OK");
        else
            $display("[ir_pulse_distance_transmitter_core] ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[ir_pulse_distance_transmitter_core] ERROR");
        $finish;
    end

endmodule

### ir_pulse_distance_transmitter_core.f
hdl/irpdt_pkg.sv
hdl/ir_pulse_distance_transmitter_core.sv
bench/tb_ir_pulse_distance_transmitter_core.sv
